// ----- hdl/kdsd_pkg.sv -----
// kdsd_pkg: types and constants shared by the key debounce / short detect block.
// Used by kdsd_front, kdsd_fifo, kdsd_back and key_debounce_and_short_detect.
`timescale 1ns / 1ps

package kdsd_pkg;

  // number of debounced key lines and of short-detect channels
  localparam int NUM_KEYS   = 3;
  localparam int NUM_SHORTS = 2;
  localparam int NSRC       = NUM_KEYS + NUM_SHORTS;
  localparam int MASK_W     = NSRC;
  localparam int SRC_W      = 3;
  localparam int LIMIT_W    = 15;
  localparam int CNT_W      = 17;

  // input word kinds
  typedef enum logic {
    FUNC_TICK      = 1'b0,
    FUNC_SHORT_RST = 1'b1
  } func_t;

  // configuration register indexes
  typedef enum logic {
    REG_MM_LIMIT  = 1'b0,
    REG_DCC_LIMIT = 1'b1
  } reg_idx_t;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(50);

  // key debouncer edge codes from the top two history bits
  localparam logic [1:0] FLIP_PRESS   = 2'b01;
  localparam logic [1:0] FLIP_RELEASE = 2'b10;

  // short counter step while the line is active
  localparam logic [CNT_W-1:0] CNT_STEP_UP = CNT_W'(2);

  // one classified item: event flags per source, the mask seen by each
  // event, and the mask after the whole item
  typedef struct packed {
    logic [NSRC-1:0]              ev;
    logic [NSRC-1:0]              make;
    logic [NSRC-1:0][MASK_W-1:0]  mask;
    logic [MASK_W-1:0]            fin;
  } kdsd_entry_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } kdsd_qstat_t;

endpackage

// ----- hdl/key_debounce_and_short_detect.sv -----
// key_debounce_and_short_detect: top level, key debouncers and booster short
// detection. Instantiates kdsd_front, kdsd_fifo and kdsd_back; uses kdsd_pkg.
`timescale 1ns / 1ps

// Each input word is a sample tick or a short-detect reset (in_tuser). A tick
// shifts the three key lines into (FILTER_LEN+1)-bit debounce histories and
// steps the two leaky short counters; the front end does all of this in the
// cycle the word is accepted and writes one entry into a two-entry queue, so
// a word can be accepted every cycle while the queue has room. The back end
// emits the entry's events (key press/release, short detected) in source
// order, one output word per cycle from a registered output stage while
// out_tready allows, then drops the entry; an item with k events gives
// max(k,1) output words, so up to five words per tick. The first output
// word of an item passes through the queue and then the output register.
// tlast marks the final word of each item.
module key_debounce_and_short_detect #(
  parameter int FILTER_LEN = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [14:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // go_key_raw, stop_key_raw, ack_line_raw,
                                  // short_a_raw, short_b_raw, 3 zero bits
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // source[2:0], is_make, active_mask[4:0],
                                  // 7 zero bits
  output logic        out_tuser,  // has_event
  output logic        out_tlast
);
  import kdsd_pkg::*;

  kdsd_qstat_t       qstat;
  kdsd_entry_t       push_data, head;
  logic              push, pop;
  logic              has_ev, is_make;
  logic [SRC_W-1:0]  source;
  logic [MASK_W-1:0] mask;

  kdsd_front #(.FILTER_LEN(FILTER_LEN)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_func   (in_tuser),
    .in_keys   (in_tdata[2:0]),
    .in_shorts (in_tdata[4:3]),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  kdsd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  kdsd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .qstat         (qstat),
    .pop           (pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_has_event (has_ev),
    .out_source    (source),
    .out_is_make   (is_make),
    .out_mask      (mask),
    .out_last      (out_tlast)
  );

  assign out_tdata = {7'b0, mask, is_make, source};
  assign out_tuser = has_ev;

endmodule

// ----- hdl/kdsd_front.sv -----
// kdsd_front: accepts input words, runs the key debouncers and short counters,
// and writes one classified entry per word into the queue. Uses kdsd_pkg.
`timescale 1ns / 1ps

module kdsd_front #(
  parameter int FILTER_LEN = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_addr,
  input  logic [kdsd_pkg::LIMIT_W-1:0]     cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_func,
  input  logic [kdsd_pkg::NUM_KEYS-1:0]    in_keys,
  input  logic [kdsd_pkg::NUM_SHORTS-1:0]  in_shorts,
  input  kdsd_pkg::kdsd_qstat_t            qstat,
  output logic                             push,
  output kdsd_pkg::kdsd_entry_t            push_data
);
  import kdsd_pkg::*;

  localparam int HW = FILTER_LEN + 1;

  logic [HW-1:0]      hist_r   [NUM_KEYS];
  logic [HW-1:0]      hist_nxt [NUM_KEYS];
  logic [CNT_W-1:0]   cnt_r    [NUM_SHORTS];
  logic [CNT_W-1:0]   cnt_nxt  [NUM_SHORTS];
  logic [CNT_W-1:0]   cnt_up   [NUM_SHORTS];
  logic [CNT_W-1:0]   lim2     [NUM_SHORTS];
  logic [LIMIT_W-1:0] limit_r  [NUM_SHORTS];
  logic [NUM_SHORTS-1:0] latch_r, latch_nxt;
  logic [MASK_W-1:0]  active_r, active_nxt;
  logic [1:0]         flip     [NUM_KEYS];
  logic               acc;
  kdsd_entry_t        ent;

  assign in_ready  = !qstat.full;
  assign acc       = in_valid && !qstat.full;
  assign push      = acc;
  assign push_data = ent;

  // debounce: shift in, fill the filter bits when the ends agree
  always_comb begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      hist_nxt[i] = {hist_r[i][HW-2:0], in_keys[i]};
      if (hist_nxt[i][FILTER_LEN-1] && hist_nxt[i][0]) begin
        hist_nxt[i][FILTER_LEN-1:0] = '1;
      end else if (!hist_nxt[i][FILTER_LEN-1] && !hist_nxt[i][0]) begin
        hist_nxt[i][FILTER_LEN-1:0] = '0;
      end
      flip[i] = hist_nxt[i][FILTER_LEN -: 2];
    end
  end

  // leaky short counters
  always_comb begin
    for (int j = 0; j < NUM_SHORTS; j++) begin
      lim2[j] = {1'b0, limit_r[j], 1'b0};
      if (in_shorts[j]) begin
        cnt_up[j] = cnt_r[j] + CNT_STEP_UP;
      end else if (cnt_r[j] != '0) begin
        cnt_up[j] = cnt_r[j] - CNT_W'(1);
      end else begin
        cnt_up[j] = cnt_r[j];
      end
    end
  end

  // build the entry and the next mask, events in source order
  always_comb begin
    ent        = '0;
    active_nxt = active_r;
    latch_nxt  = latch_r;
    for (int j = 0; j < NUM_SHORTS; j++) begin
      cnt_nxt[j] = cnt_r[j];
    end
    if (in_func == FUNC_SHORT_RST) begin
      for (int j = 0; j < NUM_SHORTS; j++) begin
        cnt_nxt[j]                = '0;
        active_nxt[NUM_KEYS + j]  = 1'b0;
      end
      latch_nxt = '0;
    end else begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        if (flip[i] == FLIP_PRESS) begin
          active_nxt[i] = 1'b1;
          ent.ev[i]     = 1'b1;
          ent.make[i]   = 1'b1;
          ent.mask[i]   = active_nxt;
        end else if (flip[i] == FLIP_RELEASE) begin
          active_nxt[i] = 1'b0;
          ent.ev[i]     = 1'b1;
          ent.mask[i]   = active_nxt;
        end
      end
      for (int j = 0; j < NUM_SHORTS; j++) begin
        if (!latch_r[j] && (cnt_up[j] > lim2[j])) begin
          latch_nxt[j]                 = 1'b1;
          active_nxt[NUM_KEYS + j]     = 1'b1;
          ent.ev[NUM_KEYS + j]         = 1'b1;
          ent.make[NUM_KEYS + j]       = 1'b1;
          ent.mask[NUM_KEYS + j]       = active_nxt;
        end
        cnt_nxt[j] = (cnt_up[j] > lim2[j]) ? lim2[j] : cnt_up[j];
      end
    end
    ent.fin = active_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        hist_r[i] <= '0;
      end
      for (int j = 0; j < NUM_SHORTS; j++) begin
        cnt_r[j] <= '0;
      end
      latch_r  <= '0;
      active_r <= '0;
    end else if (acc) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        if (in_func == FUNC_TICK) begin
          hist_r[i] <= hist_nxt[i];
        end
      end
      for (int j = 0; j < NUM_SHORTS; j++) begin
        cnt_r[j] <= cnt_nxt[j];
      end
      latch_r  <= latch_nxt;
      active_r <= active_nxt;
    end
  end

  // limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r[0] <= LIMIT_RESET;
      limit_r[1] <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_MM_LIMIT:  limit_r[0] <= cfg_wdata;
        REG_DCC_LIMIT: limit_r[1] <= cfg_wdata;
        default:       limit_r[0] <= limit_r[0];
      endcase
    end
  end

endmodule

// ----- hdl/kdsd_fifo.sv -----
// kdsd_fifo: two-entry queue of classified entries between front and back.
// Uses kdsd_pkg for the entry and status types.
`timescale 1ns / 1ps

module kdsd_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  kdsd_pkg::kdsd_entry_t  push_data,
  input  logic                   pop,
  output kdsd_pkg::kdsd_entry_t  head,
  output kdsd_pkg::kdsd_qstat_t  qstat
);
  import kdsd_pkg::*;

  kdsd_entry_t mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;

  assign qstat.full  = (cnt_r == 2'd2);
  assign qstat.empty = (cnt_r == 2'd0);
  assign head        = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && qstat.full)) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && qstat.empty)) else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");

endmodule

// ----- hdl/kdsd_back.sv -----
// kdsd_back: walks the queue head's events in source order and drives the
// registered output words, one per cycle unless stalled. Uses kdsd_pkg.
`timescale 1ns / 1ps

module kdsd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kdsd_pkg::kdsd_entry_t         head,
  input  kdsd_pkg::kdsd_qstat_t         qstat,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_has_event,
  output logic [kdsd_pkg::SRC_W-1:0]    out_source,
  output logic                          out_is_make,
  output logic [kdsd_pkg::MASK_W-1:0]   out_mask,
  output logic                          out_last
);
  import kdsd_pkg::*;

  logic [NSRC-1:0]   done_r, done_nxt;
  logic [NSRC-1:0]   pend, rest;
  logic [SRC_W-1:0]  sel;
  logic              adv, take, last_c;
  logic              valid_r;
  logic              has_r, make_r, last_r;
  logic [SRC_W-1:0]  src_r;
  logic [MASK_W-1:0] mask_r;

  // lowest pending event of the head entry
  always_comb begin
    pend = head.ev & ~done_r;
    sel  = '0;
    for (int i = NSRC - 1; i >= 0; i--) begin
      if (pend[i]) sel = SRC_W'(i);
    end
    rest   = pend & ~(NSRC'(1) << sel);
    last_c = (rest == '0);
  end

  assign adv  = !valid_r || out_ready;
  assign take = adv && !qstat.empty;
  assign pop  = take && last_c;

  always_comb begin
    done_nxt = done_r;
    if (take) begin
      done_nxt = last_c ? '0 : (done_r | (NSRC'(1) << sel));
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      done_r  <= '0;
    end else begin
      done_r <= done_nxt;
      if (adv) valid_r <= !qstat.empty;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (take) begin
      has_r  <= (pend != '0);
      src_r  <= (pend != '0) ? sel : '0;
      make_r <= (pend != '0) ? head.make[sel] : 1'b0;
      mask_r <= (pend != '0) ? head.mask[sel] : head.fin;
      last_r <= last_c;
    end
  end

  assign out_valid     = valid_r;
  assign out_has_event = has_r;
  assign out_source    = src_r;
  assign out_is_make   = make_r;
  assign out_mask      = mask_r;
  assign out_last      = last_r;

  a_mask_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !has_r |-> last_r) else $error("mask-only word not last");
  a_src_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && has_r |-> src_r < SRC_W'(NSRC)) else $error("bad source");
  a_done_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    done_r != '0 |-> !qstat.empty) else $error("events in flight without entry");
  a_pop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> valid_r && last_r) else $error("pop without final word");

endmodule
